### src/tie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tie_pkg
// Shared codes and result type of the toy ISA instruction executor.
// ----------------------------------------------------------------------------
package tie_pkg;

    localparam logic [2:0] KIND_EXEC = 3'd0;
    localparam logic [2:0] KIND_WREG = 3'd1;
    localparam logic [2:0] KIND_WMEM = 3'd2;
    localparam logic [2:0] KIND_RMEM = 3'd3;
    localparam logic [2:0] KIND_RREG = 3'd4;

    localparam logic [3:0] OP_ADD    = 4'h0;
    localparam logic [3:0] OP_SUB    = 4'h1;
    localparam logic [3:0] OP_MUL    = 4'h2;
    localparam logic [3:0] OP_INC    = 4'h3;
    localparam logic [3:0] OP_AND    = 4'h4;
    localparam logic [3:0] OP_OR     = 4'h5;
    localparam logic [3:0] OP_NOT    = 4'h6;
    localparam logic [3:0] OP_XOR    = 4'h7;
    localparam logic [3:0] OP_LOAD   = 4'h8;
    localparam logic [3:0] OP_STORE  = 4'h9;
    localparam logic [3:0] OP_JUMP   = 4'hA;
    localparam logic [3:0] OP_BRANCH = 4'hB;
    localparam logic [3:0] OP_HALT   = 4'hF;

    localparam logic [2:0] CLS_ARITH = 3'd0;
    localparam logic [2:0] CLS_LOGIC = 3'd1;
    localparam logic [2:0] CLS_MEM   = 3'd2;
    localparam logic [2:0] CLS_CTRL  = 3'd3;
    localparam logic [2:0] CLS_HALT  = 3'd4;

    typedef struct packed {
        logic [6:0] fetch_pc;
        logic       stopped;
        logic [2:0] insn_class;
        logic       jump_taken;
        logic [7:0] read_byte;
        logic       addr_fault;
    } t_result;

endpackage

### src/tie_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tie_out_fifo
// Two-entry result queue between the execute pipeline and the output bus.
// ----------------------------------------------------------------------------
module tie_out_fifo
    import tie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/toy_isa_instruction_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_isa_instruction_executor
// Executes one 16-bit instruction of a small 8-bit machine per request and
// serves register and data memory preload and readback requests.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | instr_word, target_index, load_value        | kind
//  m_axis   | out | fetch_pc, stopped, jump_taken, read_byte,   | insn_class
//           |     | addr_fault, zero pad                        |
//
//  One request per cycle while the result queue has room. A request passes
//  through register file read, execute with data memory access and write back.
//  Register operands are forwarded from the two newest write backs.
//  Reset clears pc, halt flag, register valid bits and the pipeline.
//  The pipeline freezes only while both result queue entries wait.
// ----------------------------------------------------------------------------
module toy_isa_instruction_executor
    import tie_pkg::*;
#(
    parameter int NUM_REGS   = 16,
    parameter int DATA_DEPTH = 256,
    parameter int PROG_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // instr_word, target_index, load_value
    input  logic [2:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // fetch_pc, stopped, jump_taken,
                                        // read_byte, addr_fault, pad
    output logic [2:0]  m_axis_tuser    // insn_class
);

    localparam int RW = $clog2(NUM_REGS);
    localparam int DW = $clog2(DATA_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH);

    // storage
    logic [7:0]          r_rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;
    logic [7:0]          r_dmem [DATA_DEPTH];
    logic [7:0]          r_rf_rda;
    logic [7:0]          r_rf_rdb;
    logic [7:0]          r_dm_rd;
    logic [PW-1:0]       r_pc;
    logic                r_halt;

    // issue
    logic        adv;
    logic        fifo_full;
    logic [2:0]  in_kind;
    logic [15:0] in_instr;
    logic [7:0]  in_tgt;
    logic [7:0]  in_val;
    logic [3:0]  a_sel;
    logic [7:0]  b_sel;
    logic        a_inr;
    logic        b_inr;

    // read stage
    logic          r_s1_valid;
    logic [2:0]    r_s1_kind;
    logic [15:0]   r_s1_instr;
    logic [7:0]    r_s1_tgt;
    logic [7:0]    r_s1_val;
    logic [RW-1:0] r_s1_a_idx;
    logic          r_s1_a_inr;
    logic          r_s1_a_vld;
    logic [RW-1:0] r_s1_b_idx;
    logic          r_s1_b_inr;
    logic          r_s1_b_vld;

    // write back stage
    logic          r_s2_valid;
    logic [6:0]    r_s2_pc;
    logic          r_s2_halt;
    logic [2:0]    r_s2_cls;
    logic          r_s2_taken;
    logic          r_s2_fault;
    logic [7:0]    r_s2_rbyte;
    logic          r_s2_rbmem;
    logic          r_s2_we;
    logic [RW-1:0] r_s2_widx;
    logic [7:0]    r_s2_wdata;
    logic          r_s2_wmem;

    logic          r_lw_we;
    logic [RW-1:0] r_lw_idx;
    logic [7:0]    r_lw_data;

    logic          s2_we;
    logic [7:0]    s2_wdata;

    // execute
    logic [3:0]    op;
    logic [3:0]    d_fld;
    logic [3:0]    s2_fld;
    logic          d_inr;
    logic          tgt_rinr;
    logic          tgt_dinr;
    logic [7:0]    opa;
    logic [7:0]    opb;
    logic [8:0]    addr9;
    logic          addr_ok;
    logic [7:0]    pc8;
    logic [7:0]    offs;
    logic [9:0]    next10;
    logic          out_rng;
    logic          halt_req;
    logic [15:0]   prod;
    logic [8:0]    pcx;
    logic [PW-1:0] n_pc;
    logic          n_halt;
    logic [2:0]    ex_cls;
    logic          ex_taken;
    logic          ex_fault;
    logic [7:0]    ex_rbyte;
    logic          ex_rbmem;
    logic          ex_we;
    logic [RW-1:0] ex_widx;
    logic [7:0]    ex_wdata;
    logic          ex_wmem;
    logic          dm_we;
    logic [DW-1:0] dm_waddr;
    logic [7:0]    dm_wdata;
    logic [DW-1:0] dm_raddr;

    t_result res;
    t_result out_res;

    assign adv           = !fifo_full;
    assign s_axis_tready = adv;

    assign in_kind  = s_axis_tuser;
    assign in_instr = s_axis_tdata[15:0];
    assign in_tgt   = s_axis_tdata[23:16];
    assign in_val   = s_axis_tdata[31:24];

    // register file read addresses
    always_comb begin
        a_sel = in_instr[7:4];
        if (in_kind == KIND_RREG) begin
            b_sel = in_tgt;
        end else if (in_instr[15:12] inside {OP_INC, OP_STORE, OP_BRANCH}) begin
            b_sel = {4'h0, in_instr[11:8]};
        end else begin
            b_sel = {4'h0, in_instr[3:0]};
        end
        a_inr = (a_sel != 4'h0) && (32'(a_sel) < NUM_REGS);
        b_inr = (b_sel != 8'h00) && (32'(b_sel) < NUM_REGS);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rf_rda <= r_rf[a_sel[RW-1:0]];
            r_rf_rdb <= r_rf[b_sel[RW-1:0]];
        end
        if (adv && s2_we) begin
            r_rf[r_s2_widx] <= s2_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (adv && s2_we) begin
            r_rf_vld[r_s2_widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind  <= in_kind;
            r_s1_instr <= in_instr;
            r_s1_tgt   <= in_tgt;
            r_s1_val   <= in_val;
            r_s1_a_idx <= a_sel[RW-1:0];
            r_s1_a_inr <= a_inr;
            r_s1_a_vld <= r_rf_vld[a_sel[RW-1:0]];
            r_s1_b_idx <= b_sel[RW-1:0];
            r_s1_b_inr <= b_inr;
            r_s1_b_vld <= r_rf_vld[b_sel[RW-1:0]];
        end
    end

    // forward the newest write backs over the register file data
    assign s2_we    = r_s2_valid && r_s2_we;
    assign s2_wdata = r_s2_wmem ? r_dm_rd : r_s2_wdata;

    always_comb begin
        if (r_s1_a_inr && s2_we && (r_s2_widx == r_s1_a_idx)) begin
            opa = s2_wdata;
        end else if (r_s1_a_inr && r_lw_we && (r_lw_idx == r_s1_a_idx)) begin
            opa = r_lw_data;
        end else if (r_s1_a_inr && r_s1_a_vld) begin
            opa = r_rf_rda;
        end else begin
            opa = 8'h00;
        end
        if (r_s1_b_inr && s2_we && (r_s2_widx == r_s1_b_idx)) begin
            opb = s2_wdata;
        end else if (r_s1_b_inr && r_lw_we && (r_lw_idx == r_s1_b_idx)) begin
            opb = r_lw_data;
        end else if (r_s1_b_inr && r_s1_b_vld) begin
            opb = r_rf_rdb;
        end else begin
            opb = 8'h00;
        end
    end

    // execute
    always_comb begin
        op       = r_s1_instr[15:12];
        d_fld    = r_s1_instr[11:8];
        s2_fld   = r_s1_instr[3:0];
        d_inr    = (d_fld != 4'h0) && (32'(d_fld) < NUM_REGS);
        tgt_rinr = (r_s1_tgt != 8'h00) && (32'(r_s1_tgt) < NUM_REGS);
        tgt_dinr = 32'(r_s1_tgt) < DATA_DEPTH;
        addr9    = {1'b0, opa} + {5'h00, s2_fld};
        addr_ok  = 32'(addr9) < DATA_DEPTH;
        prod     = opa * opb;
        pc8      = 8'(r_pc);

        ex_cls   = CLS_ARITH;
        ex_taken = 1'b0;
        ex_fault = 1'b0;
        ex_rbyte = 8'h00;
        ex_rbmem = 1'b0;
        ex_we    = 1'b0;
        ex_widx  = d_fld[RW-1:0];
        ex_wdata = 8'h00;
        ex_wmem  = 1'b0;
        dm_we    = 1'b0;
        dm_waddr = r_s1_tgt[DW-1:0];
        dm_wdata = r_s1_val;
        dm_raddr = r_s1_tgt[DW-1:0];
        halt_req = 1'b0;
        offs     = 8'h01;
        n_pc     = r_pc;
        n_halt   = r_halt;

        case (r_s1_kind)
            KIND_EXEC: begin
                if (r_halt) begin
                    ex_cls = CLS_HALT;
                end else begin
                    case (op)
                        OP_ADD: begin
                            ex_we    = d_inr;
                            ex_wdata = opa + opb;
                        end
                        OP_SUB: begin
                            ex_we    = d_inr;
                            ex_wdata = opa - opb;
                        end
                        OP_MUL: begin
                            ex_we    = d_inr;
                            ex_wdata = prod[7:0];
                        end
                        OP_INC: begin
                            ex_we    = d_inr;
                            ex_wdata = opb + 8'h01;
                        end
                        OP_AND: begin
                            ex_cls   = CLS_LOGIC;
                            ex_we    = d_inr;
                            ex_wdata = opa & opb;
                        end
                        OP_OR: begin
                            ex_cls   = CLS_LOGIC;
                            ex_we    = d_inr;
                            ex_wdata = opa | opb;
                        end
                        OP_NOT: begin
                            ex_cls   = CLS_LOGIC;
                            ex_we    = d_inr;
                            ex_wdata = ~opa;
                        end
                        OP_XOR: begin
                            ex_cls   = CLS_LOGIC;
                            ex_we    = d_inr;
                            ex_wdata = opa ^ opb;
                        end
                        OP_LOAD: begin
                            ex_cls = CLS_MEM;
                            ex_we  = d_inr;
                            if (addr_ok) begin
                                ex_wmem  = 1'b1;
                                dm_raddr = addr9[DW-1:0];
                            end else begin
                                ex_fault = 1'b1;
                            end
                        end
                        OP_STORE: begin
                            ex_cls = CLS_MEM;
                            if (addr_ok) begin
                                dm_we    = 1'b1;
                                dm_waddr = addr9[DW-1:0];
                                dm_wdata = opb;
                            end else begin
                                ex_fault = 1'b1;
                            end
                        end
                        OP_JUMP: begin
                            ex_cls   = CLS_CTRL;
                            ex_taken = 1'b1;
                            offs     = r_s1_instr[11:4];
                        end
                        OP_BRANCH: begin
                            ex_cls = CLS_CTRL;
                            if (opb == 8'h00) begin
                                ex_taken = 1'b1;
                                offs     = r_s1_instr[7:0];
                            end
                        end
                        OP_HALT: begin
                            ex_cls   = CLS_HALT;
                            halt_req = 1'b1;
                        end
                        default: begin
                            ex_cls = CLS_CTRL;
                        end
                    endcase
                end
            end
            KIND_WREG: begin
                ex_we    = tgt_rinr;
                ex_widx  = r_s1_tgt[RW-1:0];
                ex_wdata = r_s1_val;
            end
            KIND_WMEM: begin
                dm_we = tgt_dinr;
            end
            KIND_RMEM: begin
                ex_rbmem = tgt_dinr;
            end
            KIND_RREG: begin
                ex_rbyte = opb;
            end
            default: begin
                ex_cls = CLS_ARITH;
            end
        endcase

        next10  = {2'b00, pc8} + {{2{offs[7]}}, offs};
        out_rng = next10[9] || (next10[8:0] >= 9'(PROG_DEPTH));
        if ((r_s1_kind == KIND_EXEC) && !r_halt) begin
            if (halt_req || out_rng) begin
                n_halt = 1'b1;
            end else begin
                n_pc = next10[PW-1:0];
            end
        end
        pcx = 9'(n_pc);
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid && dm_we) begin
            r_dmem[dm_waddr] <= dm_wdata;
        end
        if (adv) begin
            r_dm_rd <= r_dmem[dm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_halt <= 1'b0;
        end else if (adv && r_s1_valid) begin
            r_pc   <= n_pc;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_pc    <= pcx[6:0];
            r_s2_halt  <= n_halt;
            r_s2_cls   <= ex_cls;
            r_s2_taken <= ex_taken;
            r_s2_fault <= ex_fault;
            r_s2_rbyte <= ex_rbyte;
            r_s2_rbmem <= ex_rbmem;
            r_s2_we    <= ex_we;
            r_s2_widx  <= ex_widx;
            r_s2_wdata <= ex_wdata;
            r_s2_wmem  <= ex_wmem;
            r_lw_idx   <= r_s2_widx;
            r_lw_data  <= s2_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_lw_we    <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= s_axis_tvalid;
            r_s2_valid <= r_s1_valid;
            r_lw_we    <= s2_we;
        end
    end

    always_comb begin
        res.fetch_pc   = r_s2_pc;
        res.stopped    = r_s2_halt;
        res.insn_class = r_s2_cls;
        res.jump_taken = r_s2_taken;
        res.read_byte  = r_s2_rbmem ? r_dm_rd : r_s2_rbyte;
        res.addr_fault = r_s2_fault;
    end

    tie_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv && r_s2_valid),
        .i_data  (res),
        .o_full  (fifo_full),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {6'h00, out_res.addr_fault, out_res.read_byte,
                           out_res.jump_taken, out_res.stopped, out_res.fetch_pc};
    assign m_axis_tuser = out_res.insn_class;

endmodule

### src/tie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tie_checker
// Port-level checks of the toy ISA instruction executor.
// ----------------------------------------------------------------------------
module tie_checker
    import tie_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic r_stop_seen;
    logic out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_seen <= 1'b0;
        end else if (out_acc && m_axis_tdata[7]) begin
            r_stop_seen <= 1'b1;
        end
    end

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_stop_seen |-> m_axis_tdata[7])
        else $error("stopped cleared after a halt");

    a_taken_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tuser == CLS_CTRL)
        else $error("jump taken outside a control instruction");

    a_fault_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tuser == CLS_MEM)
        else $error("address fault outside a memory instruction");

    a_rbyte_nonexec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[16:9] != 8'h00) |-> m_axis_tuser == CLS_ARITH)
        else $error("read byte on an executed instruction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind toy_isa_instruction_executor tie_checker u_tie_checker (.*);

### test/toy_isa_instruction_executor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_isa_instruction_executor_checker
// Watches both stream channels of the executor. Each accepted request runs
// through a shadow machine (registers, data memory, pc, halt flag), and the
// predicted result is queued. Each accepted result is compared field by
// field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module toy_isa_instruction_executor_checker
    import tie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // instr_word, target_index, load_value
    input  logic [2:0]  s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // fetch_pc, stopped, jump_taken,
                                        // read_byte, addr_fault, pad
    input  logic [2:0]  m_axis_tuser,   // insn_class
    output int          o_accepted,
    output int          o_pending,
    output int          o_checked,
    output int          o_errors,
    output logic [6:0]  o_pc
);

    localparam int NUM_REGS   = 16;
    localparam int DATA_DEPTH = 256;
    localparam int PROG_DEPTH = 128;

    logic [7:0] regs [NUM_REGS];
    logic [7:0] dmem [DATA_DEPTH];
    logic [6:0] pc;
    logic       halted;
    t_result    result_q [$];
    t_result    got;
    t_result    want;
    int         accepted;
    int         checked;
    int         errors;

    function automatic logic [7:0] reg_value(int idx);
        if (idx == 0 || idx >= NUM_REGS) return 8'h00;
        return regs[idx];
    endfunction

    function automatic void reg_store(int idx, logic [7:0] v);
        if (idx != 0 && idx < NUM_REGS) regs[idx] = v;
    endfunction

    function automatic t_result execute_request(logic [2:0] kind, logic [15:0] word,
                                                logic [7:0] tgt, logic [7:0] val);
        t_result    r;
        logic [3:0] op;
        logic [3:0] d;
        logic [3:0] s1;
        logic [3:0] s2;
        logic [7:0] a;
        logic [7:0] b;
        int         addr;
        int         next_pc;
        logic       stop;
        r = '0;
        case (kind)
            KIND_EXEC: begin
                if (halted) begin
                    r.insn_class = CLS_HALT;
                end else begin
                    op = word[15:12];
                    d  = word[11:8];
                    s1 = word[7:4];
                    s2 = word[3:0];
                    a  = reg_value(s1);
                    b  = reg_value(s2);
                    addr    = int'(a) + int'(s2);
                    next_pc = int'(pc) + 1;
                    stop    = 1'b0;
                    case (op)
                        OP_ADD: begin
                            reg_store(d, a + b);
                            r.insn_class = CLS_ARITH;
                        end
                        OP_SUB: begin
                            reg_store(d, a - b);
                            r.insn_class = CLS_ARITH;
                        end
                        OP_MUL: begin
                            reg_store(d, a * b);
                            r.insn_class = CLS_ARITH;
                        end
                        OP_INC: begin
                            reg_store(d, reg_value(d) + 8'd1);
                            r.insn_class = CLS_ARITH;
                        end
                        OP_AND: begin
                            reg_store(d, a & b);
                            r.insn_class = CLS_LOGIC;
                        end
                        OP_OR: begin
                            reg_store(d, a | b);
                            r.insn_class = CLS_LOGIC;
                        end
                        OP_NOT: begin
                            reg_store(d, ~a);
                            r.insn_class = CLS_LOGIC;
                        end
                        OP_XOR: begin
                            reg_store(d, a ^ b);
                            r.insn_class = CLS_LOGIC;
                        end
                        OP_LOAD: begin
                            r.insn_class = CLS_MEM;
                            if (addr < DATA_DEPTH) begin
                                reg_store(d, dmem[addr]);
                            end else begin
                                reg_store(d, 8'h00);
                                r.addr_fault = 1'b1;
                            end
                        end
                        OP_STORE: begin
                            r.insn_class = CLS_MEM;
                            if (addr < DATA_DEPTH) dmem[addr] = reg_value(d);
                            else r.addr_fault = 1'b1;
                        end
                        OP_JUMP: begin
                            r.insn_class = CLS_CTRL;
                            r.jump_taken = 1'b1;
                            next_pc = int'(pc) + int'($signed(word[11:4]));
                        end
                        OP_BRANCH: begin
                            r.insn_class = CLS_CTRL;
                            if (reg_value(d) == 8'h00) begin
                                r.jump_taken = 1'b1;
                                next_pc = int'(pc) + int'($signed(word[7:0]));
                            end
                        end
                        OP_HALT: begin
                            r.insn_class = CLS_HALT;
                            stop = 1'b1;
                        end
                        default: r.insn_class = CLS_CTRL;
                    endcase
                    if (stop || next_pc < 0 || next_pc >= PROG_DEPTH) halted = 1'b1;
                    else pc = next_pc[6:0];
                end
            end
            KIND_WREG: reg_store(tgt, val);
            KIND_WMEM: if (tgt < DATA_DEPTH) dmem[tgt] = val;
            KIND_RMEM: if (tgt < DATA_DEPTH) r.read_byte = dmem[tgt];
            KIND_RREG: r.read_byte = reg_value(tgt);
            default: ;
        endcase
        r.fetch_pc = pc;
        r.stopped  = halted;
        return r;
    endfunction

    task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (regs[i]) regs[i] = 8'h00;
            pc     = '0;
            halted = 1'b0;
            result_q.delete();
        end else begin
            // compare before queueing, so a result never meets a same-edge request
            if (m_axis_tvalid && m_axis_tready) begin
                got.fetch_pc   = m_axis_tdata[6:0];
                got.stopped    = m_axis_tdata[7];
                got.jump_taken = m_axis_tdata[8];
                got.read_byte  = m_axis_tdata[16:9];
                got.addr_fault = m_axis_tdata[17];
                got.insn_class = m_axis_tuser;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, got %h / %h",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = result_q.pop_front();
                    checked++;
                    compare_field("fetch_pc",   want.fetch_pc,   got.fetch_pc);
                    compare_field("stopped",    want.stopped,    got.stopped);
                    compare_field("insn_class", want.insn_class, got.insn_class);
                    compare_field("jump_taken", want.jump_taken, got.jump_taken);
                    compare_field("read_byte",  want.read_byte,  got.read_byte);
                    compare_field("addr_fault", want.addr_fault, got.addr_fault);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                result_q.insert(result_q.size(),
                                execute_request(s_axis_tuser, s_axis_tdata[15:0],
                                                s_axis_tdata[23:16], s_axis_tdata[31:24]));
                accepted++;
            end
        end
        o_pc       <= pc;
        o_pending  <= result_q.size();
        o_accepted <= accepted;
        o_checked  <= checked;
        o_errors   <= errors;
    end

endmodule

### test/toy_isa_instruction_executor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_isa_instruction_executor_tb
// Drives the executor with a memory preload, a directed pass over every
// opcode and corner case, a long random program that stays inside program
// range, and a final halt followed by requests to the stopped machine.
// Both stream sides idle at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module toy_isa_instruction_executor_tb;
    import tie_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 100;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // instr_word, target_index, load_value
    logic [2:0]  s_axis_tuser  = KIND_EXEC;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // fetch_pc, stopped, jump_taken,
                                        // read_byte, addr_fault, pad
    logic [2:0]  m_axis_tuser;          // insn_class

    int         accepted_cnt;
    int         pending_cnt;
    int         checked_cnt;
    int         error_cnt;
    logic [6:0] model_pc;

    int         sent;
    int         cycles;
    logic [6:0] track_pc;
    bit         pc_known = 1'b1;
    bit         tx_busy  = 1'b1;
    string      halt_how;

    always #5 i_clk = ~i_clk;

    toy_isa_instruction_executor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    toy_isa_instruction_executor_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_accepted    (accepted_cnt),
        .o_pending     (pending_cnt),
        .o_checked     (checked_cnt),
        .o_errors      (error_cnt),
        .o_pc          (model_pc)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(logic [2:0] kind, logic [15:0] word, logic [7:0] tgt,
                        logic [7:0] val);
        int gap;
        gap = tx_busy ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {val, tgt, word};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // send an instruction and follow its effect on pc
    task automatic exec(logic [15:0] word);
        send(KIND_EXEC, word, 8'($urandom), 8'($urandom));
        case (word[15:12])
            OP_JUMP: track_pc = track_pc + word[11:4];
            OP_BRANCH: begin
                if (word[11:8] == 4'd0) track_pc = track_pc + word[7:0];
                else pc_known = 1'b0;
            end
            default: track_pc = track_pc + 7'd1;
        endcase
    endtask

    // hold requests until every result is back, then take pc from the checker
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (accepted_cnt != sent || pending_cnt != 0);
        track_pc = model_pc;
        pc_known = 1'b1;
    endtask

    // keep jumps and branches inside program range; never halt
    function automatic logic [15:0] random_instr();
        logic [15:0] w;
        int          target;
        w = 16'($urandom);
        w[15:12] = (track_pc == 7'd127) ? OP_JUMP : 4'($urandom_range(0, 14));
        target = $urandom_range(0, 127);
        if (w[15:12] == OP_JUMP) w[11:4] = 8'(target - int'(track_pc));
        if (w[15:12] == OP_BRANCH) w[7:0] = 8'(target - int'(track_pc));
        return w;
    endfunction

    // result sink: random stalls, quiet stretches, and one long hold
    initial begin
        int gap;
        int got;
        bit rx_busy;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (got % 60 == 0) rx_busy = $urandom_range(0, 2) != 0;
            gap = rx_busy ? $urandom_range(0, 16) : 0;
            if (got == 150) gap = 200;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got++;
        end
    end

    initial begin
        int pick;
        track_pc = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill data memory so no load ever reads an unwritten byte
        for (int a = 0; a < 256; a++) send(KIND_WMEM, 16'($urandom), 8'(a), 8'($urandom));

        send(KIND_WREG, 16'h0000, 8'd0, 8'hFF);
        send(KIND_RREG, 16'h0000, 8'd0, 8'h00);
        send(KIND_WREG, 16'h0000, 8'd1, 8'hFF);
        send(KIND_WREG, 16'h0000, 8'd2, 8'h01);
        send(KIND_WREG, 16'h0000, 8'd3, 8'h80);
        send(KIND_WREG, 16'h0000, 8'd9, 8'hFF);
        send(KIND_WREG, 16'hFFFF, 8'd200, 8'h55);
        send(KIND_RREG, 16'hFFFF, 8'd255, 8'hFF);
        exec({OP_ADD, 4'd4, 4'd1, 4'd2});
        exec({OP_SUB, 4'd5, 4'd2, 4'd1});
        exec({OP_MUL, 4'd6, 4'd1, 4'd3});
        exec({OP_INC, 4'd1, 4'd0, 4'd0});
        exec({OP_AND, 4'd7, 4'd3, 4'd9});
        exec({OP_OR,  4'd8, 4'd2, 4'd3});
        exec({OP_NOT, 4'd10, 4'd3, 4'd0});
        exec({OP_XOR, 4'd11, 4'd9, 4'd3});
        exec({OP_LOAD, 4'd12, 4'd3, 4'd15});
        exec({OP_LOAD, 4'd13, 4'd9, 4'd1});
        exec({OP_STORE, 4'd12, 4'd9, 4'd15});
        exec({OP_STORE, 4'd9, 4'd2, 4'd0});
        send(KIND_RMEM, 16'h0000, 8'd1, 8'h00);
        exec({OP_ADD, 4'd0, 4'd9, 4'd9});
        exec({OP_JUMP, 8'd5, 4'd0});
        exec({OP_BRANCH, 4'd0, 8'hFE});
        exec(16'hC123);
        exec(16'hE0FF);
        exec({OP_BRANCH, 4'd9, 8'h10});
        send(3'd5, 16'hFFFF, 8'hFF, 8'hFF);
        send(3'd7, 16'h0000, 8'h00, 8'h00);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) tx_busy = $urandom_range(0, 2) != 0;
            if (n == RANDOM_ITEMS / 2 || !pc_known) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                exec(random_instr());
            end else if (pick < 83) begin
                send(KIND_WREG, 16'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                     8'($urandom));
            end else if (pick < 88) begin
                send(KIND_WMEM, 16'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 93) begin
                send(KIND_RMEM, 16'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 97) begin
                send(KIND_RREG, 16'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                     8'($urandom));
            end else begin
                send(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        // stop the machine once, by one of three routes
        drain_results();
        case ($urandom_range(0, 2))
            0: begin
                halt_how = "halt opcode";
                exec({OP_HALT, 12'($urandom)});
            end
            1: begin
                halt_how = "jump below zero";
                exec({OP_JUMP, 8'(-int'($urandom_range(int'(track_pc) + 1, 128))),
                      4'($urandom)});
            end
            default: begin
                halt_how = "run past the last address";
                exec({OP_JUMP, 8'(127 - int'(track_pc)), 4'($urandom)});
                exec({OP_XOR, 12'($urandom)});
            end
        endcase
        for (int n = 0; n < 4; n++) exec(16'($urandom));
        exec({OP_HALT, 12'($urandom)});
        send(KIND_WREG, 16'($urandom), 8'd5, 8'($urandom));
        send(KIND_RREG, 16'($urandom), 8'd5, 8'($urandom));
        send(KIND_WMEM, 16'($urandom), 8'd7, 8'($urandom));
        send(KIND_RMEM, 16'($urandom), 8'd7, 8'($urandom));
        send(3'd6, 16'($urandom), 8'($urandom), 8'($urandom));
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests (%0d random), checked %0d results, %0d mismatches.",
                 sent, RANDOM_ITEMS, checked_cnt, error_cnt);
        $display("Covered all opcodes, preload and readback, faults, halt by %s.", halt_how);
        if (error_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
